### src/assert_macros.svh
// Assertion helpers shared by the RTL. Both sample on clk and are disabled in rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### src/dsr_pkg.sv
package dsr_pkg;

  localparam int MAX_OUT_SCALE = 28;

  localparam int MANT_W      = 192;
  localparam int LIMB_W      = 32;
  localparam int NUM_LIMBS   = MANT_W / LIMB_W;
  localparam int LIMB_CNT_W  = $clog2(NUM_LIMBS);
  localparam int OUT_W       = 96;
  localparam int FIELD_W     = 64;
  localparam int OUT_HIGH_W  = OUT_W - FIELD_W;
  localparam int SCALE_W     = 6;
  localparam int OUT_SCALE_W = 5;
  localparam int REM_W       = 4;

  localparam int DIVISOR     = 10;
  localparam int HALF_DIGIT  = 5;

  // 2^32 = 10 * LIMB_QUOT + LIMB_REM, and RECIP_TEN = ceil(2^35 / 10).
  localparam logic [LIMB_W-1:0] LIMB_QUOT   = 32'd429496729;
  localparam int                LIMB_REM    = 6;
  localparam logic [LIMB_W-1:0] RECIP_TEN   = 32'd3435973837;
  localparam int                RECIP_SHIFT = 35;

  typedef logic [LIMB_W-1:0] limb_t;
  typedef logic [REM_W-1:0]  rem_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_POS_OVF   = 2'd1,
    STATUS_NEG_OVF   = 2'd2,
    STATUS_UNDERFLOW = 2'd3
  } status_t;

endpackage

### src/dsr_if.sv
interface dsr_in_if import dsr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] mant_low;
  logic [FIELD_W-1:0] mant_mid;
  logic [FIELD_W-1:0] mant_high;
  logic [SCALE_W-1:0] scale;
  logic               negative;
  logic [SCALE_W-1:0] target_scale;

  modport source (output valid, mant_low, mant_mid, mant_high, scale, negative, target_scale,
                  input ready);
  modport sink (input valid, mant_low, mant_mid, mant_high, scale, negative, target_scale,
                output ready);
endinterface

interface dsr_out_if import dsr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [FIELD_W-1:0]     out_low;
  logic [OUT_HIGH_W-1:0]  out_high;
  logic [OUT_SCALE_W-1:0] out_scale;
  logic                   out_negative;
  status_t                status;

  modport source (output valid, out_low, out_high, out_scale, out_negative, status,
                  input ready);
  modport sink (input valid, out_low, out_high, out_scale, out_negative, status,
                output ready);
endinterface

### src/decimal_scale_reduce_round.sv
// Steps: each divide-by-ten step passes through decide, six 32-bit limbs, then round.
// An item is taken in idle, runs its steps and ends in finish; the fit phase hands over
// to the scale phase through an extra decide state, and an item needs up to 63 steps.
// Throughput: one item at a time; the shared limb divider sets the rate.
// Reset: synchronous active-high rst returns to idle and empties the output register.
`include "assert_macros.svh"

module decimal_scale_reduce_round import dsr_pkg::*; (
  input logic   clk,
  input logic   rst,
  dsr_in_if.sink     operand,
  dsr_out_if.source  result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_DIV,
    S_ROUND,
    S_FINISH
  } state_t;

  state_t                  state;
  logic [MANT_W-1:0]       mant;
  logic [SCALE_W-1:0]      scale_r;
  logic [SCALE_W-1:0]      target;
  logic                    neg;
  logic                    phase2;
  logic                    p2_stepped;
  rem_t                    rem;
  logic [LIMB_CNT_W-1:0]   limb_cnt;
  status_t                 fin_status;

  logic                    out_valid;
  logic [FIELD_W-1:0]      out_low;
  logic [OUT_HIGH_W-1:0]   out_high;
  logic [OUT_SCALE_W-1:0]  out_scale;
  logic                    out_negative;
  status_t                 out_status;

  limb_t                   quot;
  rem_t                    rem_next;
  logic                    too_wide;
  logic                    in_too_wide;
  logic                    is_zero;
  logic                    fit_go;
  logic                    round_up;

  dsr_div10 u_div10 (
    .limb    (mant[MANT_W-1 -: LIMB_W]),
    .rem_in  (rem),
    .quot    (quot),
    .rem_out (rem_next)
  );

  assign too_wide    = |mant[MANT_W-1:OUT_W];
  assign in_too_wide = |{operand.mant_high, operand.mant_mid[FIELD_W-1:OUT_W-FIELD_W]};
  assign is_zero     = ~|mant;
  assign round_up    = (rem > REM_W'(HALF_DIGIT)) || ((rem == REM_W'(HALF_DIGIT)) && mant[0]);

  always_comb begin
    if (target == '0) begin
      fit_go = too_wide && (scale_r != '0);
    end else begin
      fit_go = (scale_r != '0) && (too_wide || (scale_r > target));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      rem        <= '0;
      limb_cnt   <= '0;
      phase2     <= 1'b0;
      p2_stepped <= 1'b0;
    end else begin
      if (result.ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (operand.valid) begin
            mant       <= {operand.mant_high, operand.mant_mid, operand.mant_low};
            scale_r    <= operand.scale;
            target     <= operand.target_scale;
            neg        <= operand.negative;
            phase2     <= ~in_too_wide;
            p2_stepped <= 1'b0;
            state      <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (!phase2) begin
            if (fit_go) begin
              rem      <= '0;
              limb_cnt <= '0;
              state    <= S_DIV;
            end else if (too_wide) begin
              fin_status <= neg ? STATUS_NEG_OVF : STATUS_POS_OVF;
              state      <= S_FINISH;
            end else begin
              phase2 <= 1'b1;
            end
          end else begin
            if (p2_stepped && is_zero) begin
              fin_status <= STATUS_UNDERFLOW;
              state      <= S_FINISH;
            end else if (scale_r > SCALE_W'(MAX_OUT_SCALE)) begin
              rem      <= '0;
              limb_cnt <= '0;
              state    <= S_DIV;
            end else begin
              fin_status <= STATUS_OK;
              state      <= S_FINISH;
            end
          end
        end
        S_DIV: begin
          mant <= {mant[MANT_W-LIMB_W-1:0], quot};
          rem  <= rem_next;
          if (limb_cnt == LIMB_CNT_W'(NUM_LIMBS - 1)) begin
            state <= S_ROUND;
          end else begin
            limb_cnt <= limb_cnt + 1'b1;
          end
        end
        S_ROUND: begin
          if (round_up) begin
            mant <= mant + 1'b1;
          end
          scale_r <= scale_r - 1'b1;
          if (phase2) begin
            p2_stepped <= 1'b1;
          end
          state <= S_DECIDE;
        end
        S_FINISH: begin
          if (!out_valid || result.ready) begin
            if (fin_status == STATUS_OK) begin
              out_low      <= mant[FIELD_W-1:0];
              out_high     <= mant[OUT_W-1:FIELD_W];
              out_scale    <= scale_r[OUT_SCALE_W-1:0];
              out_negative <= neg;
            end else begin
              out_low      <= '0;
              out_high     <= '0;
              out_scale    <= '0;
              out_negative <= 1'b0;
            end
            out_status <= fin_status;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign operand.ready       = (state == S_IDLE);
  assign result.valid        = out_valid;
  assign result.out_low      = out_low;
  assign result.out_high     = out_high;
  assign result.out_scale    = out_scale;
  assign result.out_negative = out_negative;
  assign result.status       = out_status;

  `ASSERT_IMPLIES(a_error_clears, result.valid && (result.status != STATUS_OK),
    (result.out_low == '0) && (result.out_high == '0) && (result.out_scale == '0) &&
    !result.out_negative, "Error result carries a nonzero field.")
  `ASSERT_IMPLIES(a_ok_scale, result.valid && (result.status == STATUS_OK),
    result.out_scale <= OUT_SCALE_W'(MAX_OUT_SCALE), "Ok result has scale above the maximum.")
  `ASSERT_ALWAYS(a_rem_digit, rem <= REM_W'(DIVISOR - 1),
    "Carried remainder is not a decimal digit.")
  `ASSERT_IMPLIES(a_limb_range, state == S_DIV, limb_cnt <= LIMB_CNT_W'(NUM_LIMBS - 1),
    "Limb counter ran past the last limb.")

endmodule

### src/dsr_div10.sv
module dsr_div10 import dsr_pkg::*; (
  input  limb_t limb,
  input  rem_t  rem_in,
  output limb_t quot,
  output rem_t  rem_out
);

  logic [LIMB_W:0]     folded;
  logic [2*LIMB_W:0]   prod;
  limb_t               q_fold;
  limb_t               q_carry;
  logic [LIMB_W:0]     back;

  // The carried remainder times 2^32 splits into a whole multiple of ten and a small rest
  // that is folded into the limb before the reciprocal multiply.
  assign folded  = (LIMB_W+1)'(rem_in) * (LIMB_W+1)'(LIMB_REM) + (LIMB_W+1)'(limb);
  assign prod    = (2*LIMB_W+1)'(folded) * (2*LIMB_W+1)'(RECIP_TEN);
  assign q_fold  = LIMB_W'(prod >> RECIP_SHIFT);
  assign q_carry = LIMB_W'(rem_in) * LIMB_QUOT;
  assign quot    = q_carry + q_fold;
  assign back    = folded - (LIMB_W+1)'(q_fold) * (LIMB_W+1)'(DIVISOR);
  assign rem_out = REM_W'(back);

endmodule
